// File: rtl/vmt_pkg.sv
// ----------------------------------------------------------------------------
// vmt_pkg
// Shared constants for the virtio-mmio version 2 transport register block.
// ----------------------------------------------------------------------------
`default_nettype none

package vmt_pkg;

    localparam int NUM_QUEUES     = 2;
    localparam int QUEUE_SIZE_MAX = 256;
    localparam int QIDX_W         = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    localparam logic SIZE_OK_RST =
        ((QUEUE_SIZE_MAX & (QUEUE_SIZE_MAX - 1)) == 0) && (QUEUE_SIZE_MAX != 0);

    localparam logic [31:0] MAGIC_VALUE     = 32'h7472_6976;
    localparam logic [31:0] VERSION_VALUE   = 32'd2;
    localparam logic [15:0] DEVICE_ID_RST   = 16'd3;
    localparam logic [31:0] VENDOR_ID_RST   = 32'h4b4d_564d;
    localparam logic [31:0] QSIZE_MAX_VALUE = 32'(QUEUE_SIZE_MAX);
    localparam logic [31:0] NUM_QUEUES_W    = 32'(NUM_QUEUES);

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic CFG_DEVICE_ID = 1'b0;
    localparam logic CFG_VENDOR_ID = 1'b1;

    localparam logic [11:0] OFF_MAGIC        = 12'h000;
    localparam logic [11:0] OFF_VERSION      = 12'h004;
    localparam logic [11:0] OFF_DEVICE_ID    = 12'h008;
    localparam logic [11:0] OFF_VENDOR_ID    = 12'h00c;
    localparam logic [11:0] OFF_DEV_FEAT     = 12'h010;
    localparam logic [11:0] OFF_DEV_FEAT_SEL = 12'h014;
    localparam logic [11:0] OFF_DRV_FEAT     = 12'h020;
    localparam logic [11:0] OFF_DRV_FEAT_SEL = 12'h024;
    localparam logic [11:0] OFF_QUEUE_SEL    = 12'h030;
    localparam logic [11:0] OFF_QUEUE_MAX    = 12'h034;
    localparam logic [11:0] OFF_QUEUE_SIZE   = 12'h038;
    localparam logic [11:0] OFF_QUEUE_READY  = 12'h044;
    localparam logic [11:0] OFF_NOTIFY       = 12'h050;
    localparam logic [11:0] OFF_IRQ_STATUS   = 12'h060;
    localparam logic [11:0] OFF_IRQ_ACK      = 12'h064;
    localparam logic [11:0] OFF_STATUS       = 12'h070;
    localparam logic [11:0] OFF_DESC_LO      = 12'h080;
    localparam logic [11:0] OFF_DESC_HI      = 12'h084;
    localparam logic [11:0] OFF_AVAIL_LO     = 12'h090;
    localparam logic [11:0] OFF_AVAIL_HI     = 12'h094;
    localparam logic [11:0] OFF_USED_LO      = 12'h0a0;
    localparam logic [11:0] OFF_USED_HI      = 12'h0a4;

endpackage

`default_nettype wire

// File: rtl/virtio_mmio_transport_registers_core.sv
// ----------------------------------------------------------------------------
// virtio_mmio_transport_registers_core
// Virtio-mmio version 2 register block: decodes one bus access per cycle.
// ----------------------------------------------------------------------------
// Result: the result of an access is strobed on done in the cycle after start.
// Throughput: one access per cycle; busy stays low, the decode and update
// path from the access ports to the result and state registers sets it.
// Reset: rst_n returns the transport state and the identity registers to
// their reset values. A status write of zero returns the transport state to reset.
// Results cannot be stalled by the receiver.
`default_nettype none

module virtio_mmio_transport_registers_core
    import vmt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        func,
    input  wire logic [11:0] offset,
    input  wire logic [31:0] wdata,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_wdata,
    output logic             done,
    output logic [31:0]      rdata,
    output logic             kick,
    output logic [2:0]       kick_queue,
    output logic             irq
);

    logic [15:0]             device_id_reg;
    logic [31:0]             vendor_id_reg;

    logic                    sel_valid_reg,  sel_valid_next;
    logic [QIDX_W-1:0]       sel_idx_reg,    sel_idx_next;
    logic [31:0]             queue_ready_reg [NUM_QUEUES];
    logic [31:0]             queue_ready_next[NUM_QUEUES];
    logic [NUM_QUEUES-1:0]   ready_nz_reg,   ready_nz_next;
    logic [NUM_QUEUES-1:0]   size_ok_reg,    size_ok_next;
    logic                    dev_sel_one_reg, dev_sel_one_next;
    logic [31:0]             irq_status_reg, irq_status_next;
    logic [31:0]             status_reg,     status_next;

    logic                    done_reg;
    logic [31:0]             rdata_reg,      rdata_next;
    logic                    kick_reg,       kick_next;
    logic [2:0]              kick_queue_reg, kick_queue_next;
    logic                    irq_reg;

    logic                    accept;
    logic [QIDX_W-1:0]       qi;
    logic [QIDX_W-1:0]       nidx;
    logic                    notify_in_range;
    logic                    wdata_pow2;

    assign busy            = 1'b0;
    assign accept          = start && !busy;
    assign qi              = sel_valid_reg ? sel_idx_reg : '0;
    assign nidx            = wdata[QIDX_W-1:0];
    assign notify_in_range = wdata < NUM_QUEUES_W;
    assign wdata_pow2      = (wdata != 32'd0) && ((wdata & (wdata - 32'd1)) == 32'd0);

    always_comb
    begin
        sel_valid_next   = sel_valid_reg;
        sel_idx_next     = sel_idx_reg;
        queue_ready_next = queue_ready_reg;
        ready_nz_next    = ready_nz_reg;
        size_ok_next     = size_ok_reg;
        dev_sel_one_next = dev_sel_one_reg;
        irq_status_next  = irq_status_reg;
        status_next      = status_reg;
        rdata_next       = 32'd0;
        kick_next        = 1'b0;
        kick_queue_next  = 3'd0;

        if (func == FUNC_READ)
        begin
            case (offset)
                OFF_MAGIC:       rdata_next = MAGIC_VALUE;
                OFF_VERSION:     rdata_next = VERSION_VALUE;
                OFF_DEVICE_ID:   rdata_next = {16'd0, device_id_reg};
                OFF_VENDOR_ID:   rdata_next = vendor_id_reg;
                OFF_DEV_FEAT:    rdata_next = {31'd0, dev_sel_one_reg};
                OFF_QUEUE_MAX:   rdata_next = QSIZE_MAX_VALUE;
                OFF_QUEUE_READY: rdata_next = sel_valid_reg ? queue_ready_reg[sel_idx_reg]
                                                            : 32'd0;
                OFF_IRQ_STATUS:  rdata_next = irq_status_reg;
                OFF_STATUS:      rdata_next = status_reg;
                default:         rdata_next = 32'd0;
            endcase
        end
        else
        begin
            case (offset)
                OFF_DEV_FEAT_SEL: dev_sel_one_next = (wdata == 32'd1);
                OFF_QUEUE_SEL:
                begin
                    sel_valid_next = wdata < NUM_QUEUES_W;
                    sel_idx_next   = wdata[QIDX_W-1:0];
                end
                OFF_QUEUE_SIZE:   size_ok_next[qi] = wdata_pow2;
                OFF_QUEUE_READY:
                begin
                    queue_ready_next[qi] = wdata;
                    ready_nz_next[qi]    = (wdata != 32'd0);
                end
                OFF_NOTIFY:
                begin
                    if (notify_in_range && ready_nz_reg[nidx] && size_ok_reg[nidx])
                    begin
                        kick_next          = 1'b1;
                        kick_queue_next    = wdata[2:0];
                        irq_status_next[0] = 1'b1;
                    end
                end
                OFF_IRQ_ACK:      irq_status_next = irq_status_reg & ~wdata;
                OFF_STATUS:
                begin
                    if (wdata == 32'd0)
                    begin
                        sel_valid_next   = 1'b1;
                        sel_idx_next     = '0;
                        for (int i = 0; i < NUM_QUEUES; i++)
                        begin
                            queue_ready_next[i] = 32'd0;
                        end
                        ready_nz_next    = '0;
                        size_ok_next     = {NUM_QUEUES{SIZE_OK_RST}};
                        dev_sel_one_next = 1'b0;
                        irq_status_next  = 32'd0;
                        status_next      = 32'd0;
                    end
                    else
                    begin
                        status_next = wdata;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id_reg <= DEVICE_ID_RST;
            vendor_id_reg <= VENDOR_ID_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEVICE_ID: device_id_reg <= cfg_wdata[15:0];
                CFG_VENDOR_ID: vendor_id_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_valid_reg   <= 1'b1;
            sel_idx_reg     <= '0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                queue_ready_reg[i] <= 32'd0;
            end
            ready_nz_reg    <= '0;
            size_ok_reg     <= {NUM_QUEUES{SIZE_OK_RST}};
            dev_sel_one_reg <= 1'b0;
            irq_status_reg  <= 32'd0;
            status_reg      <= 32'd0;
            done_reg        <= 1'b0;
            kick_reg        <= 1'b0;
            irq_reg         <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            kick_reg <= accept && kick_next;
            if (accept)
            begin
                sel_valid_reg   <= sel_valid_next;
                sel_idx_reg     <= sel_idx_next;
                queue_ready_reg <= queue_ready_next;
                ready_nz_reg    <= ready_nz_next;
                size_ok_reg     <= size_ok_next;
                dev_sel_one_reg <= dev_sel_one_next;
                irq_status_reg  <= irq_status_next;
                status_reg      <= status_next;
                irq_reg         <= (irq_status_next != 32'd0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg      <= rdata_next;
            kick_queue_reg <= kick_queue_next;
        end
    end

    assign done       = done_reg;
    assign rdata      = rdata_reg;
    assign kick       = kick_reg;
    assign kick_queue = kick_queue_reg;
    assign irq        = irq_reg;

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("accepted transfer produced no result");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !start |=> !done)
        else $error("result strobe without an accepted transfer");

    a_kick_sets_irq: assert property (@(posedge clk) disable iff (!rst_n)
        kick |-> (done && irq))
        else $error("kick without result strobe or interrupt");

    a_irq_tracks_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (irq == (irq_status_reg != 32'd0)))
        else $error("irq does not match interrupt status");

endmodule

`default_nettype wire
